// ===== rtl/fsc_pkg.sv =====
// Shared types and constants of the fan speed controller.
package fsc_pkg;

    localparam int TEMP_W   = 16;
    localparam int SPEED_W  = 8;
    localparam int TICK_W   = 16;
    localparam int CFG_AW   = 3;
    localparam int CFG_DW   = 16;
    localparam int PROD_W   = TEMP_W + SPEED_W;
    localparam int DIV_CNT_W = $clog2(SPEED_W);

    localparam logic [CFG_AW-1:0] REG_TEMP_LOW      = 3'd0;
    localparam logic [CFG_AW-1:0] REG_TEMP_HIGH     = 3'd1;
    localparam logic [CFG_AW-1:0] REG_FAIL_CODE     = 3'd2;
    localparam logic [CFG_AW-1:0] REG_MAX_SPEED     = 3'd3;
    localparam logic [CFG_AW-1:0] REG_MIN_SPEED     = 3'd4;
    localparam logic [CFG_AW-1:0] REG_STARTUP_SPEED = 3'd5;
    localparam logic [CFG_AW-1:0] REG_MIN_RUN_TICKS = 3'd6;

    // Source of the target speed for the current tick.
    typedef enum logic [1:0] {
        TGT_MAX    = 2'd0,
        TGT_ZERO   = 2'd1,
        TGT_HOLD   = 2'd2,
        TGT_INTERP = 2'd3
    } tgt_kind_t;

    typedef struct packed {
        logic load;
        logic prep;
        logic step;
        logic finish;
    } fsc_cmd_t;

    typedef struct packed {
        logic div_last;
        logic out_free;
    } fsc_sts_t;

endpackage

// ===== rtl/fsc_ctrl.sv =====
// Sequencer that steps one tick through capture, setup, division and update.
module fsc_ctrl import fsc_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  fsc_sts_t sts,
    output fsc_cmd_t cmd
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PREP = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_DONE = 4'b1000
    } state_t;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_ready  = 1'b1;
                cmd.load = s_valid;
                if (s_valid) begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: begin
                cmd.prep   = 1'b1;
                state_next = ST_DIV;
            end
            ST_DIV: begin
                cmd.step = 1'b1;
                if (sts.div_last) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // Hold here until the previous result has been taken.
                if (sts.out_free) begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== rtl/fsc_datapath.sv =====
// Configuration registers, target speed arithmetic, divider and run state.
module fsc_datapath import fsc_pkg::*; (
    input  logic                      aclk,
    input  logic                      aresetn,
    input  logic                      cfg_wr_en,
    input  logic [CFG_AW-1:0]         cfg_addr,
    input  logic [CFG_DW-1:0]         cfg_wdata,
    input  logic signed [TEMP_W-1:0]  s_temperature,
    output logic                      m_valid,
    input  logic                      m_ready,
    output logic [SPEED_W-1:0]        m_speed,
    output logic                      m_running,
    input  fsc_cmd_t                  cmd,
    output fsc_sts_t                  sts
);

    logic signed [TEMP_W-1:0] temp_low_reg, temp_high_reg, fail_code_reg;
    logic [SPEED_W-1:0]       max_speed_reg, min_speed_reg, startup_speed_reg;
    logic [TICK_W-1:0]        min_run_ticks_reg;

    logic signed [TEMP_W-1:0] temp_reg;
    tgt_kind_t                kind_reg, kind_next;
    logic                     neg_reg;
    logic [TEMP_W-1:0]        span_reg;
    logic [TEMP_W-1:0]        rem_reg, rem_next;
    logic [SPEED_W-1:0]       quo_reg, quo_next;
    logic [DIV_CNT_W-1:0]     cnt_reg;

    logic                     run_state_reg, run_state_next;
    logic [TICK_W-1:0]        run_timer_reg, run_timer_next;
    logic [SPEED_W-1:0]       last_speed_reg;
    logic                     m_valid_reg;
    logic [SPEED_W-1:0]       m_speed_reg;
    logic                     m_running_reg;

    logic [TEMP_W:0]          diff_full, span_full;
    logic [SPEED_W:0]         range_full, range_mag;
    logic [PROD_W-1:0]        product;
    logic [TEMP_W:0]          trial_div, trial;
    logic [SPEED_W-1:0]       target, speed_pre, speed_out;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            temp_low_reg      <= 16'sd400;
            temp_high_reg     <= 16'sd600;
            fail_code_reg     <= 16'sh8000;
            max_speed_reg     <= 8'd100;
            min_speed_reg     <= 8'd20;
            startup_speed_reg <= 8'd50;
            min_run_ticks_reg <= 16'd10;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                REG_TEMP_LOW:      temp_low_reg      <= cfg_wdata;
                REG_TEMP_HIGH:     temp_high_reg     <= cfg_wdata;
                REG_FAIL_CODE:     fail_code_reg     <= cfg_wdata;
                REG_MAX_SPEED:     max_speed_reg     <= cfg_wdata[SPEED_W-1:0];
                REG_MIN_SPEED:     min_speed_reg     <= cfg_wdata[SPEED_W-1:0];
                REG_STARTUP_SPEED: startup_speed_reg <= cfg_wdata[SPEED_W-1:0];
                REG_MIN_RUN_TICKS: min_run_ticks_reg <= cfg_wdata[TICK_W-1:0];
                default: ;
            endcase
        end
    end

    // Classification and the numerator of the interpolation.
    always_comb begin
        diff_full  = {temp_reg[TEMP_W-1], temp_reg} - {temp_low_reg[TEMP_W-1], temp_low_reg};
        span_full  = {temp_high_reg[TEMP_W-1], temp_high_reg}
                   - {temp_low_reg[TEMP_W-1], temp_low_reg};
        range_full = {1'b0, max_speed_reg} - {1'b0, min_speed_reg};
        range_mag  = range_full[SPEED_W] ? ((SPEED_W+1)'(0) - range_full) : range_full;
        product    = PROD_W'(diff_full[TEMP_W-1:0]) * PROD_W'(range_mag[SPEED_W-1:0]);

        if (temp_high_reg == fail_code_reg || temp_reg == fail_code_reg) begin
            kind_next = TGT_MAX;
        end else if (temp_low_reg < temp_high_reg) begin
            if (temp_reg > temp_high_reg) begin
                kind_next = TGT_MAX;
            end else if (temp_reg < temp_low_reg) begin
                kind_next = TGT_ZERO;
            end else begin
                kind_next = TGT_INTERP;
            end
        end else begin
            if (temp_reg > temp_low_reg) begin
                kind_next = TGT_MAX;
            end else if (temp_reg < temp_high_reg) begin
                kind_next = TGT_ZERO;
            end else begin
                kind_next = TGT_HOLD;
            end
        end
    end

    // One restoring division step. The quotient never exceeds the speed
    // range, so the upper product bits start out as the partial remainder.
    always_comb begin
        trial_div = {rem_reg, quo_reg[SPEED_W-1]};
        trial     = trial_div - {1'b0, span_reg};
        if (!trial[TEMP_W]) begin
            rem_next = trial[TEMP_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], 1'b1};
        end else begin
            rem_next = trial_div[TEMP_W-1:0];
            quo_next = {quo_reg[SPEED_W-2:0], 1'b0};
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            temp_reg <= s_temperature;
        end
        if (cmd.prep) begin
            kind_reg <= kind_next;
            neg_reg  <= range_full[SPEED_W];
            span_reg <= span_full[TEMP_W-1:0];
            rem_reg  <= product[PROD_W-1:SPEED_W];
            quo_reg  <= product[SPEED_W-1:0];
        end else if (cmd.step) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (cmd.prep) begin
            cnt_reg <= '0;
        end else if (cmd.step) begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Target selection and the off/run state machine.
    always_comb begin
        case (kind_reg)
            TGT_MAX:    target = max_speed_reg;
            TGT_ZERO:   target = '0;
            TGT_HOLD:   target = last_speed_reg;
            TGT_INTERP: target = neg_reg ? (min_speed_reg - quo_reg)
                                         : (min_speed_reg + quo_reg);
            default:    target = '0;
        endcase

        run_state_next = run_state_reg;
        run_timer_next = run_timer_reg;
        if (!run_state_reg) begin
            if (target > min_speed_reg) begin
                speed_pre      = startup_speed_reg;
                run_state_next = 1'b1;
                run_timer_next = min_run_ticks_reg;
            end else begin
                speed_pre = '0;
            end
        end else if (run_timer_reg != '0) begin
            run_timer_next = run_timer_reg - 1'b1;
            speed_pre      = (target < min_speed_reg) ? min_speed_reg : target;
        end else if (target < min_speed_reg) begin
            speed_pre      = '0;
            run_state_next = 1'b0;
        end else begin
            speed_pre = target;
        end
        speed_out = (speed_pre > max_speed_reg) ? max_speed_reg : speed_pre;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_state_reg  <= 1'b0;
            run_timer_reg  <= '0;
            last_speed_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cmd.finish) begin
                run_state_reg  <= run_state_next;
                run_timer_reg  <= run_timer_next;
                last_speed_reg <= speed_out;
                m_valid_reg    <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.finish) begin
            m_speed_reg   <= speed_out;
            m_running_reg <= run_state_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_speed      = m_speed_reg;
    assign m_running    = m_running_reg;
    assign sts.div_last = (cnt_reg == DIV_CNT_W'(SPEED_W - 1));
    assign sts.out_free = !m_valid_reg || m_ready;

endmodule

// ===== rtl/fan_speed_controller.sv =====
// Fan speed controller: one temperature tick in, one speed and running flag out. A tick
// occupies the block from the capture cycle in which it is accepted, through a setup step that
// classifies the temperature and forms the interpolation product and the bit-serial divider
// (one quotient bit per cycle), to an update cycle. The next tick is accepted no earlier than
// the cycle in which the result becomes valid. The result waits in an output register, so
// the block starts the next tick while a result is still pending; it only stalls in the
// update cycle if that result is not taken.
module fan_speed_controller import fsc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_wr_en,
    input  logic [CFG_AW-1:0]        cfg_addr,
    input  logic [CFG_DW-1:0]        cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic signed [TEMP_W-1:0] s_temperature,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [SPEED_W-1:0]       m_speed,
    output logic                     m_running
);

    fsc_cmd_t cmd;
    fsc_sts_t sts;

    fsc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    fsc_datapath u_datapath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_temperature (s_temperature),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed       (m_speed),
        .m_running     (m_running),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== rtl/fsc_checker.sv =====
// Port-level checks of the fan speed controller, bound to the top level.
module fsc_checker import fsc_pkg::*; (
    input logic                     aclk,
    input logic                     aresetn,
    input logic                     s_valid,
    input logic                     s_ready,
    input logic signed [TEMP_W-1:0] s_temperature,
    input logic                     m_valid,
    input logic                     m_ready,
    input logic [SPEED_W-1:0]       m_speed,
    input logic                     m_running
);

    // A waiting input transaction keeps its payload.
    a_in_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && !s_ready |=> s_valid && $stable(s_temperature))
        else $error("input changed while waiting");

    // A stalled result transaction keeps its payload.
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_speed) && $stable(m_running))
        else $error("result changed while stalled");

    // A fan that is off is driven at zero speed.
    a_off_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_running |-> m_speed == '0)
        else $error("nonzero speed reported with fan off");

    // Ticks are processed one at a time.
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input taken while a tick is in progress");

    // A new result does not appear during the setup step or the first division step after acceptance.
    a_no_early_result: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready && !m_valid |=> !m_valid ##1 !m_valid)
        else $error("result appeared too early");

endmodule

bind fan_speed_controller fsc_checker u_fsc_checker (
    .aclk          (aclk),
    .aresetn       (aresetn),
    .s_valid       (s_valid),
    .s_ready       (s_ready),
    .s_temperature (s_temperature),
    .m_valid       (m_valid),
    .m_ready       (m_ready),
    .m_speed       (m_speed),
    .m_running     (m_running)
);

// ===== tb/tb_fan_speed_controller.sv =====
// Self-checking testbench for the fan speed controller with a built-in speed predictor.
module tb_fan_speed_controller;
    import fsc_pkg::*;

    typedef struct packed {
        logic [SPEED_W-1:0] speed;
        logic               running;
    } fan_out_t;

    logic                     aclk;
    logic                     aresetn;
    logic                     cfg_wr_en;
    logic [CFG_AW-1:0]        cfg_addr;
    logic [CFG_DW-1:0]        cfg_wdata;
    logic                     s_valid;
    logic                     s_ready;
    logic signed [TEMP_W-1:0] s_temperature;
    logic                     m_valid;
    logic                     m_ready;
    logic [SPEED_W-1:0]       m_speed;
    logic                     m_running;

    fan_speed_controller uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_temperature (s_temperature),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_speed       (m_speed),
        .m_running     (m_running)
    );

    // Predictor copy of the configuration registers.
    logic signed [TEMP_W-1:0] thr_low;
    logic signed [TEMP_W-1:0] thr_high;
    logic signed [TEMP_W-1:0] sensor_fail;
    logic [SPEED_W-1:0]       speed_max;
    logic [SPEED_W-1:0]       speed_min;
    logic [SPEED_W-1:0]       speed_kick;
    logic [TICK_W-1:0]        run_ticks;

    // Predictor copy of the controller state.
    logic                     fan_on;
    logic [TICK_W-1:0]        fan_timer;
    logic [SPEED_W-1:0]       prev_speed;

    fan_out_t   expected_speeds[$];
    fan_out_t   oldest;
    int         mismatches;
    int         hold_left;
    int         burst_left;
    int         rx_phase_left;
    int         rx_mode;
    int         rx_index;
    logic [15:0] rx_pattern;

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    initial begin
        #4000000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [SPEED_W-1:0] target_speed(logic signed [TEMP_W-1:0] t);
        int diff;
        int span;
        int range;
        int q;
        if (thr_high == sensor_fail || t == sensor_fail) return speed_max;
        if (thr_low < thr_high) begin
            if (t > thr_high) return speed_max;
            if (t < thr_low) return '0;
            diff  = int'(t) - int'(thr_low);
            span  = int'(thr_high) - int'(thr_low);
            range = int'(speed_max) - int'(speed_min);
            q     = (diff * range) / span;
            return SPEED_W'(int'(speed_min) + q);
        end
        if (t > thr_low) return speed_max;
        if (t < thr_high) return '0;
        return prev_speed;
    endfunction

    function automatic fan_out_t advance_fan(logic signed [TEMP_W-1:0] t);
        fan_out_t r;
        logic [SPEED_W-1:0] s;
        s = target_speed(t);
        if (!fan_on) begin
            if (s > speed_min) begin
                s         = speed_kick;
                fan_on    = 1'b1;
                fan_timer = run_ticks;
            end else begin
                s = '0;
            end
        end else if (fan_timer != '0) begin
            fan_timer = fan_timer - 1'b1;
            if (s < speed_min) s = speed_min;
        end else if (s < speed_min) begin
            s      = '0;
            fan_on = 1'b0;
        end
        if (s > speed_max) s = speed_max;
        prev_speed = s;
        r.speed    = s;
        r.running  = fan_on;
        return r;
    endfunction

    task automatic report_error(string what, fan_out_t exp_r, fan_out_t act_r);
        mismatches++;
        if (mismatches <= 10)
            $display("%s: expected speed %0d running %0b, got speed %0d running %0b",
                     what, exp_r.speed, exp_r.running, act_r.speed, act_r.running);
    endtask

    // Result checker: every accepted result transaction is matched against the oldest
    // expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            if (expected_speeds.size() == 0) begin
                report_error("unexpected result", '0, {m_speed, m_running});
            end else begin
                oldest = expected_speeds.pop_front();
                if (m_speed !== oldest.speed || m_running !== oldest.running)
                    report_error("result mismatch", oldest, {m_speed, m_running});
            end
        end
    end

    // Receiver: a long hold when requested, otherwise phases of steady, patterned or
    // random readiness.
    initial begin
        m_ready = 1'b0;
        rx_phase_left = 0;
        rx_index = 0;
        forever begin
            @(negedge aclk);
            if (hold_left > 0) begin
                hold_left--;
                m_ready = 1'b0;
            end else begin
                if (rx_phase_left == 0) begin
                    rx_phase_left = $urandom_range(20, 200);
                    rx_mode       = $urandom_range(0, 2);
                    rx_pattern    = 16'($urandom()) | 16'h0001;
                end
                rx_phase_left--;
                rx_index++;
                case (rx_mode)
                    0: begin
                        m_ready = 1'b1;
                    end
                    1: begin
                        m_ready = rx_pattern[rx_index % 16];
                    end
                    default: begin
                        m_ready = ($urandom_range(0, 9) < 7);
                    end
                endcase
            end
        end
    end

    task automatic write_reg(logic [CFG_AW-1:0] idx, logic [CFG_DW-1:0] data);
        @(negedge aclk);
        cfg_wr_en = 1'b1;
        cfg_addr  = idx;
        cfg_wdata = data;
        case (idx)
            REG_TEMP_LOW:      thr_low     = data;
            REG_TEMP_HIGH:     thr_high    = data;
            REG_FAIL_CODE:     sensor_fail = data;
            REG_MAX_SPEED:     speed_max   = data[SPEED_W-1:0];
            REG_MIN_SPEED:     speed_min   = data[SPEED_W-1:0];
            REG_STARTUP_SPEED: speed_kick  = data[SPEED_W-1:0];
            REG_MIN_RUN_TICKS: run_ticks   = data;
            default: ;
        endcase
        @(negedge aclk);
        cfg_wr_en = 1'b0;
    endtask

    // The upper byte of the narrow registers carries random junk that must be dropped.
    task automatic program_regs(int lo, int hi, int fail, int vmax, int vmin, int kick,
                                int ticks);
        write_reg(REG_TEMP_LOW, 16'(lo));
        write_reg(REG_TEMP_HIGH, 16'(hi));
        write_reg(REG_FAIL_CODE, 16'(fail));
        write_reg(REG_MAX_SPEED, {8'($urandom()), 8'(vmax)});
        write_reg(REG_MIN_SPEED, {8'($urandom()), 8'(vmin)});
        write_reg(REG_STARTUP_SPEED, {8'($urandom()), 8'(kick)});
        write_reg(REG_MIN_RUN_TICKS, 16'(ticks));
    endtask

    task automatic send_tick(logic signed [TEMP_W-1:0] t);
        @(negedge aclk);
        s_valid       = 1'b1;
        s_temperature = t;
        do @(posedge aclk); while (!s_ready);
        expected_speeds.push_back(advance_fan(t));
    endtask

    task automatic pause_sender(int n);
        repeat (n) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
    endtask

    // Drop valid, let every expected result arrive, then give the block time to go idle.
    task automatic settle();
        pause_sender(1);
        while (expected_speeds.size() != 0) @(posedge aclk);
        repeat (12) @(posedge aclk);
    endtask

    function automatic logic signed [TEMP_W-1:0] pick_temperature();
        int a;
        int b;
        int v;
        int sel;
        sel = $urandom_range(0, 99);
        if (sel < 60) begin
            a = ((thr_low < thr_high) ? int'(thr_low) : int'(thr_high)) - 64;
            b = ((thr_low < thr_high) ? int'(thr_high) : int'(thr_low)) + 64;
            v = a + int'($urandom_range(0, b - a));
            if (v > 32767) v = 32767;
            if (v < -32768) v = -32768;
            return 16'(v);
        end
        if (sel < 70) return sensor_fail;
        if (sel < 80) return ($urandom_range(0, 1) == 0) ? 16'sh7FFF : 16'sh8000;
        return 16'($urandom());
    endfunction

    task automatic stream_ticks(int n, bit gaps_on);
        repeat (n) begin
            if (gaps_on && burst_left == 0) begin
                pause_sender($urandom_range(1, 12));
                burst_left = $urandom_range(1, 25);
            end
            if (burst_left > 0) burst_left--;
            send_tick(pick_temperature());
        end
    endtask

    function automatic int pick_speed();
        case ($urandom_range(0, 5))
            0: return 0;
            1: return 255;
            default: return $urandom_range(0, 255);
        endcase
    endfunction

    function automatic int pick_ticks();
        case ($urandom_range(0, 9))
            0: return 0;
            1: return 65535;
            default: return $urandom_range(0, 20);
        endcase
    endfunction

    function automatic int pick_fail(int hi);
        case ($urandom_range(0, 7))
            0: return hi;
            1: return -32768;
            2: return 32767;
            default: return $urandom_range(0, 65535) - 32768;
        endcase
    endfunction

    task automatic randomize_proportional();
        int span;
        int lo;
        span = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 600);
        lo   = $urandom_range(0, 65535) - 32768;
        if (lo + span > 32767) lo = 32767 - span;
        program_regs(lo, lo + span, pick_fail(lo + span), pick_speed(), pick_speed(),
                     pick_speed(), pick_ticks());
    endtask

    task automatic randomize_relay();
        int hi;
        int lo;
        hi = $urandom_range(0, 65535) - 32768;
        lo = hi + $urandom_range(0, 400);
        if (lo > 32767) lo = 32767;
        program_regs(lo, hi, pick_fail(hi), pick_speed(), pick_speed(), pick_speed(),
                     pick_ticks());
    endtask

    task automatic test_reset_defaults();
        send_tick(16'sd500);
        send_tick(16'sd600);
        send_tick(16'sd601);
        send_tick(16'sh7FFF);
        send_tick(16'sd399);
        send_tick(16'sh8000);
        settle();
    endtask

    task automatic test_special_cases();
        // Full-range proportional band; the kick-start speed is above the clamp.
        program_regs(-32768, 32767, 0, 250, 5, 255, 0);
        send_tick(16'sh7FFF);
        send_tick(16'sh8000);
        send_tick(16'sd0);
        settle();
        // Maximum below minimum: the interpolation runs downward while the timer runs out.
        program_regs(-32768, 32767, 0, 10, 200, 255, 3);
        send_tick(16'sh8000);
        send_tick(16'sd16384);
        send_tick(16'sd1000);
        send_tick(16'sh7FFF);
        send_tick(16'sd16384);
        settle();
        // Equal thresholds select the relay and its hold band.
        program_regs(100, 100, -32768, 255, 0, 7, 2);
        send_tick(16'sd100);
        send_tick(16'sd101);
        send_tick(16'sd100);
        send_tick(16'sd99);
        send_tick(16'sd101);
        settle();
        // The failure code equals the upper threshold, so every tick runs at full speed.
        program_regs(200, -200, -200, 90, 30, 40, 1);
        send_tick(16'sd0);
        send_tick(16'sh8000);
        settle();
        // A write to an unused index must leave all registers alone.
        write_reg(3'd7, 16'($urandom()));
        write_reg(REG_FAIL_CODE, 16'sh8000);
        send_tick(16'sd0);
        send_tick(16'sd201);
        send_tick(16'sd0);
        send_tick(-16'sd201);
        settle();
    endtask

    task automatic test_random_proportional();
        repeat (6) begin
            randomize_proportional();
            stream_ticks(50, $urandom_range(0, 3) != 0);
            settle();
        end
    endtask

    task automatic test_random_relay();
        repeat (4) begin
            randomize_relay();
            stream_ticks(50, $urandom_range(0, 3) != 0);
            settle();
        end
    endtask

    // The receiver holds off long enough for the block to fill and stall its input.
    task automatic test_output_stall();
        randomize_proportional();
        @(posedge aclk);
        hold_left = 400;
        stream_ticks(40, 1'b0);
        settle();
    endtask

    task automatic test_random_wide();
        repeat (4) begin
            program_regs($urandom_range(0, 65535), $urandom_range(0, 65535),
                         $urandom_range(0, 65535), $urandom_range(0, 255),
                         $urandom_range(0, 255), $urandom_range(0, 255),
                         $urandom_range(0, 65535));
            stream_ticks(40, 1'b1);
            settle();
        end
    endtask

    initial begin
        int wait_cycles;
        aresetn       = 1'b0;
        cfg_wr_en     = 1'b0;
        cfg_addr      = '0;
        cfg_wdata     = '0;
        s_valid       = 1'b0;
        s_temperature = '0;
        mismatches    = 0;
        hold_left     = 0;
        burst_left    = 0;
        thr_low       = 16'sd400;
        thr_high      = 16'sd600;
        sensor_fail   = 16'sh8000;
        speed_max     = 8'd100;
        speed_min     = 8'd20;
        speed_kick    = 8'd50;
        run_ticks     = 16'd10;
        fan_on        = 1'b0;
        fan_timer     = '0;
        prev_speed    = '0;
        repeat (2) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_special_cases();
        test_random_proportional();
        test_random_relay();
        test_output_stall();
        test_random_wide();

        pause_sender(1);
        wait_cycles = 0;
        while (expected_speeds.size() != 0 && wait_cycles < 5000) begin
            @(posedge aclk);
            wait_cycles++;
        end
        repeat (20) @(posedge aclk);
        if (expected_speeds.size() != 0) begin
            mismatches += expected_speeds.size();
            $display("%0d expected results never arrived", expected_speeds.size());
        end
        if (mismatches == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
